### src/http_header_field_parser_assert.svh
// assertion macros shared by the parser rtl
`ifndef HTTP_HEADER_FIELD_PARSER_ASSERT_SVH
`define HTTP_HEADER_FIELD_PARSER_ASSERT_SVH

// consequence must hold in the same cycle as the trigger
`define HHFP_ASSERT_IMPLY(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("hhfp check failed");

// condition must never be seen
`define HHFP_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hhfp check failed");

`endif

### src/hhfp_pkg.sv
package hhfp_pkg;

    localparam int WS_DEPTH = 16;
    localparam int CNT_W    = $clog2(WS_DEPTH + 1);
    localparam int IDX_W    = $clog2(WS_DEPTH);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [2:0] {
        ROLE_NAME       = 3'd0,
        ROLE_VALUE      = 3'd1,
        ROLE_FIELD_END  = 3'd2,
        ROLE_HEADER_END = 3'd3,
        ROLE_MALFORMED  = 3'd4
    } role_t;

    typedef enum logic [3:0] {
        PH_LINE_START = 4'd0,
        PH_NAME       = 4'd1,
        PH_LEAD       = 4'd2,
        PH_VALUE      = 4'd3,
        PH_CR_LEAD    = 4'd4,
        PH_CR_VALUE   = 4'd5,
        PH_LF_LEAD    = 4'd6,
        PH_LF_VALUE   = 4'd7,
        PH_EMPTY_CR   = 4'd8,
        PH_DONE       = 4'd9,
        PH_ERROR      = 4'd10
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_FOLD,
        SQ_DRAIN,
        SQ_LAST,
        SQ_TAIL
    } seq_t;

    typedef struct packed {
        logic [7:0] value;
        role_t      role;
        logic       last;
    } result_t;

    typedef struct packed {
        logic             idle;
        logic [CNT_W-1:0] count;
    } status_t;

    function automatic logic is_token(input logic [7:0] b);
        is_token = b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                             8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
                             8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C,
                             8'h7E};
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        is_space = b inside {CH_SP, [CH_HT:CH_CR]};
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b == CH_SP) || (b == CH_HT);
    endfunction

endpackage

### src/http_header_field_parser.sv
// channel   signals                              beat carries
// data      data_valid, data_stall               data_byte, block_start
// result    result_valid, result_stall           out_byte, role, run_last
//
// a byte that releases n held whitespace bytes makes one ram read per held
// byte and is sent after them, and a fold makes three ram writes; the input
// stalls meanwhile. a field end followed by a name byte stalls it as well.
// reset clears phase, held count and the result valid flag; the ram and the result data are not cleared.
// a stalled result register holds the input side stalled as well.
module http_header_field_parser
    import hhfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    output logic       data_stall,
    input  logic [7:0] data_byte,
    input  logic       block_start,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic [2:0] role,
    output logic       run_last
);

    logic    slot_free;
    logic    emit;
    result_t result;
    status_t status;

    hhfp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_valid  (data_valid),
        .data_byte   (data_byte),
        .block_start (block_start),
        .data_stall  (data_stall),
        .slot_free   (slot_free),
        .emit        (emit),
        .result      (result),
        .status      (status)
    );

    hhfp_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .result       (result),
        .slot_free    (slot_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .role         (role),
        .run_last     (run_last)
    );

`include "http_header_field_parser_assert.svh"

    `HHFP_ASSERT_NEVER(a_count_bound, status.count > CNT_W'(WS_DEPTH))
    `HHFP_ASSERT_IMPLY(a_busy_stalls, !status.idle, data_stall)
    `HHFP_ASSERT_IMPLY(a_mark_zero, result_valid && role != ROLE_NAME && role != ROLE_VALUE,
        out_byte == 8'h00)
    `HHFP_ASSERT_IMPLY(a_malformed_last, result_valid && role == ROLE_MALFORMED, run_last)

endmodule

### src/hhfp_ram.sv
module hhfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/hhfp_ctrl.sv
module hhfp_ctrl
    import hhfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       data_valid,
    input  logic [7:0] data_byte,
    input  logic       block_start,
    output logic       data_stall,
    input  logic       slot_free,
    output logic       emit,
    output result_t    result,
    output status_t    status
);

    seq_t             seq_reg, seq_next;
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       held_reg, held_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             fold_reg, fold_next;

    logic             accept;
    phase_t           cur_phase;
    logic [CNT_W-1:0] cur_count;
    logic             cur_full;
    logic             reg_full;
    logic             more_held;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;

    hhfp_ram #(
        .WIDTH (8),
        .DEPTH (WS_DEPTH)
    ) u_ws_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign data_stall = !((seq_reg == SQ_IDLE) && slot_free);
    assign accept     = data_valid && !data_stall;
    assign cur_phase  = block_start ? PH_LINE_START : phase_reg;
    assign cur_count  = block_start ? '0 : count_reg;
    assign cur_full   = cur_count >= CNT_W'(WS_DEPTH);
    assign reg_full   = count_reg >= CNT_W'(WS_DEPTH);
    // another held byte still to read after the one now on the ram output
    assign more_held  = (CNT_W'(idx_reg) + CNT_W'(1)) < count_reg;

    assign status.idle  = (seq_reg == SQ_IDLE);
    assign status.count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= SQ_IDLE;
            phase_reg <= PH_LINE_START;
            count_reg <= '0;
            idx_reg   <= '0;
            fold_reg  <= 1'b0;
        end
        else
        begin
            seq_reg   <= seq_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            fold_reg  <= fold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    // next state
    always_comb
    begin
        seq_next   = seq_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        held_next  = held_reg;
        idx_next   = idx_reg;
        fold_next  = fold_reg;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    phase_next = cur_phase;
                    count_next = cur_count;
                    case (cur_phase)
                        PH_LINE_START:
                        begin
                            if (data_byte == CH_CR)
                                phase_next = PH_EMPTY_CR;
                            else if (is_token(data_byte))
                                phase_next = PH_NAME;
                            else
                                phase_next = PH_ERROR;
                        end
                        PH_NAME:
                        begin
                            if (is_token(data_byte))
                                phase_next = PH_NAME;
                            else if (data_byte == CH_COLON)
                                phase_next = PH_LEAD;
                            else
                                phase_next = PH_ERROR;
                        end
                        PH_LEAD:
                        begin
                            if (data_byte == CH_CR)
                                phase_next = PH_CR_LEAD;
                            else if (!is_space(data_byte))
                                phase_next = PH_VALUE;
                        end
                        PH_VALUE:
                        begin
                            if (data_byte == CH_CR)
                            begin
                                phase_next = PH_CR_VALUE;
                            end
                            else if (is_space(data_byte))
                            begin
                                if (cur_full)
                                begin
                                    phase_next = PH_ERROR;
                                    count_next = '0;
                                end
                                else
                                begin
                                    count_next = cur_count + CNT_W'(1);
                                end
                            end
                            else if (cur_count != '0)
                            begin
                                seq_next  = SQ_DRAIN;
                                held_next = data_byte;
                                idx_next  = '0;
                            end
                        end
                        PH_CR_LEAD:
                        begin
                            phase_next = (data_byte == CH_LF) ? PH_LF_LEAD : PH_ERROR;
                        end
                        PH_CR_VALUE:
                        begin
                            phase_next = (data_byte == CH_LF) ? PH_LF_VALUE : PH_ERROR;
                        end
                        PH_LF_LEAD:
                        begin
                            phase_next = is_blank(data_byte) ? PH_LEAD : PH_ERROR;
                        end
                        PH_LF_VALUE:
                        begin
                            if (is_blank(data_byte))
                            begin
                                // fold: two spaces then the blank itself
                                if (cur_full)
                                begin
                                    phase_next = PH_ERROR;
                                    count_next = '0;
                                end
                                else
                                begin
                                    phase_next = PH_VALUE;
                                    count_next = cur_count + CNT_W'(1);
                                    seq_next   = SQ_FOLD;
                                    fold_next  = 1'b0;
                                    held_next  = data_byte;
                                end
                            end
                            else
                            begin
                                count_next = '0;
                                if (data_byte == CH_CR)
                                begin
                                    phase_next = PH_EMPTY_CR;
                                end
                                else
                                begin
                                    phase_next = is_token(data_byte) ? PH_NAME : PH_ERROR;
                                    seq_next   = SQ_TAIL;
                                    held_next  = data_byte;
                                end
                            end
                        end
                        PH_EMPTY_CR:
                        begin
                            phase_next = (data_byte == CH_LF) ? PH_DONE : PH_ERROR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            SQ_FOLD:
            begin
                if (slot_free)
                begin
                    if (reg_full)
                    begin
                        phase_next = PH_ERROR;
                        count_next = '0;
                        seq_next   = SQ_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        fold_next  = 1'b1;
                        if (fold_reg)
                            seq_next = SQ_IDLE;
                    end
                end
            end
            SQ_DRAIN:
            begin
                if (slot_free)
                begin
                    if (more_held)
                        idx_next = idx_reg + IDX_W'(1);
                    else
                        seq_next = SQ_LAST;
                end
            end
            SQ_LAST:
            begin
                if (slot_free)
                begin
                    count_next = '0;
                    seq_next   = SQ_IDLE;
                end
            end
            SQ_TAIL:
            begin
                if (slot_free)
                    seq_next = SQ_IDLE;
            end
            default:
            begin
                seq_next = SQ_IDLE;
            end
        endcase
    end

    // results and ram access
    always_comb
    begin
        emit         = 1'b0;
        result.value = 8'h00;
        result.role  = ROLE_MALFORMED;
        result.last  = 1'b1;
        wr_en        = 1'b0;
        wr_addr      = cur_count[IDX_W-1:0];
        wr_data      = data_byte;
        rd_en        = 1'b0;
        rd_addr      = '0;
        case (seq_reg)
            SQ_IDLE:
            begin
                if (accept)
                begin
                    case (cur_phase)
                        PH_LINE_START:
                        begin
                            if (is_token(data_byte))
                            begin
                                emit         = 1'b1;
                                result.value = data_byte;
                                result.role  = ROLE_NAME;
                            end
                            else if (data_byte != CH_CR)
                            begin
                                emit = 1'b1;
                            end
                        end
                        PH_NAME:
                        begin
                            if (is_token(data_byte))
                            begin
                                emit         = 1'b1;
                                result.value = data_byte;
                                result.role  = ROLE_NAME;
                            end
                            else if (data_byte != CH_COLON)
                            begin
                                emit = 1'b1;
                            end
                        end
                        PH_LEAD:
                        begin
                            if (data_byte != CH_CR && !is_space(data_byte))
                            begin
                                emit         = 1'b1;
                                result.value = data_byte;
                                result.role  = ROLE_VALUE;
                            end
                        end
                        PH_VALUE:
                        begin
                            if (data_byte == CH_CR)
                            begin
                            end
                            else if (is_space(data_byte))
                            begin
                                if (cur_full)
                                    emit = 1'b1;
                                else
                                    wr_en = 1'b1;
                            end
                            else if (cur_count == '0)
                            begin
                                emit         = 1'b1;
                                result.value = data_byte;
                                result.role  = ROLE_VALUE;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                            end
                        end
                        PH_CR_LEAD, PH_CR_VALUE, PH_EMPTY_CR:
                        begin
                            if (data_byte != CH_LF)
                            begin
                                emit = 1'b1;
                            end
                            else if (cur_phase == PH_EMPTY_CR)
                            begin
                                emit        = 1'b1;
                                result.role = ROLE_HEADER_END;
                            end
                        end
                        PH_LF_LEAD:
                        begin
                            emit = !is_blank(data_byte);
                        end
                        PH_LF_VALUE:
                        begin
                            if (is_blank(data_byte))
                            begin
                                if (cur_full)
                                begin
                                    emit = 1'b1;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    wr_data = CH_SP;
                                end
                            end
                            else
                            begin
                                // a bare cr on the new line marks the field end as last; its lf then emits header end
                                emit        = 1'b1;
                                result.role = ROLE_FIELD_END;
                                result.last = (data_byte == CH_CR);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            SQ_FOLD:
            begin
                if (slot_free)
                begin
                    if (reg_full)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wr_addr = count_reg[IDX_W-1:0];
                        wr_data = fold_reg ? held_reg : CH_SP;
                    end
                end
            end
            SQ_DRAIN:
            begin
                if (slot_free)
                begin
                    emit         = 1'b1;
                    result.value = rd_data;
                    result.role  = ROLE_VALUE;
                    result.last  = 1'b0;
                    rd_en        = more_held;
                    rd_addr      = idx_reg + IDX_W'(1);
                end
            end
            SQ_LAST:
            begin
                if (slot_free)
                begin
                    emit         = 1'b1;
                    result.value = held_reg;
                    result.role  = ROLE_VALUE;
                end
            end
            SQ_TAIL:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (is_token(held_reg))
                    begin
                        result.value = held_reg;
                        result.role  = ROLE_NAME;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### src/hhfp_out.sv
module hhfp_out
    import hhfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       emit,
    input  result_t    result,
    output logic       slot_free,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic [2:0] role,
    output logic       run_last
);

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    assign slot_free  = !valid_reg || !result_stall;
    assign valid_next = slot_free ? emit : valid_reg;
    assign data_next  = (slot_free && emit) ? result : data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign result_valid = valid_reg;
    assign out_byte     = data_reg.value;
    assign role         = data_reg.role;
    assign run_last     = data_reg.last;

endmodule
